### src/gfle_pkg.sv
// gfle_pkg: shared types and constants of the galois field log/antilog unit
`timescale 1ns / 1ps

package gfle_pkg;

  localparam int unsigned MAX_FIELD_BITS = 12;
  localparam int unsigned MIN_FIELD_BITS = 2;
  localparam int unsigned POLY_W         = 13;
  localparam int unsigned FBITS_W        = 4;
  localparam int unsigned VALUE_W        = 12;
  localparam int unsigned APB_DATA_W     = 32;
  localparam int unsigned APB_ADDR_W     = 3;

  localparam logic [POLY_W-1:0]  POLY_RESET = 13'h11D;
  localparam logic [FBITS_W-1:0] BITS_RESET = 4'd8;

  typedef enum logic [1:0] {
    OP_MUL   = 2'd0,
    OP_INV   = 2'd1,
    OP_LOG   = 2'd2,
    OP_BUILD = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ZERO      = 2'd1,
    ST_NOT_BUILT = 2'd2
  } status_e;

  typedef enum logic {
    REG_POLY = 1'b0,
    REG_BITS = 1'b1
  } reg_e;

  typedef struct packed {
    logic alog_we;
    logic log_we;
    logic done;
  } bld_t;

endpackage

### src/galois_field_log_exp_alu.sv
// galois_field_log_exp_alu: gf(2^m) multiply, inverse and log from log/antilog tables
// states after accept: log S_LA, inverse S_LA then S_AX, multiply S_LA, S_LB then S_AX; rejected word none
// a new word is taken once busy drops, so the unit works on one word at a time
// build runs two passes: one writes antilog and clears log, then one fills log
// each table is one memory with a registered read port; lookups chain through those reads
// rst_ni clears control and configuration; tables are unbuilt until the first build word
`timescale 1ns / 1ps

module galois_field_log_exp_alu #(
  parameter int unsigned MaxFieldBits = gfle_pkg::MAX_FIELD_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [gfle_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [gfle_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [gfle_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready,
  input  logic                              start,
  input  logic [1:0]                        opcode_i,
  input  logic [gfle_pkg::VALUE_W-1:0]      operand_a_i,
  input  logic [gfle_pkg::VALUE_W-1:0]      operand_b_i,
  output logic                              busy,
  output logic                              valid_o,
  output logic [gfle_pkg::VALUE_W-1:0]      value_o,
  output logic [1:0]                        status_o
);

  localparam int unsigned BW    = $clog2(MaxFieldBits + 1);
  localparam int unsigned Depth = 1 << MaxFieldBits;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BUILD,
    S_LA,
    S_LB,
    S_AX
  } state_e;

  state_e                          state_q;
  gfle_pkg::op_e                   op_q;
  logic [MaxFieldBits-1:0]         b_q;
  logic [MaxFieldBits-1:0]         la_q;
  logic [BW-1:0]                   bits_q;
  logic                            built_q;
  logic                            valid_q;
  logic [gfle_pkg::VALUE_W-1:0]    value_q;
  gfle_pkg::status_e               status_q;

  logic [gfle_pkg::POLY_W-1:0]     poly;
  logic [gfle_pkg::FBITS_W-1:0]    fbits;
  logic [BW-1:0]                   bits_clamp;
  logic [MaxFieldBits-1:0]         mask;
  logic [MaxFieldBits-1:0]         a_in;
  logic [MaxFieldBits-1:0]         b_in;
  gfle_pkg::op_e                   op_in;
  logic                            accept;

  gfle_pkg::bld_t                  bld;
  logic [MaxFieldBits-1:0]         alog_waddr;
  logic [MaxFieldBits-1:0]         alog_wdata;
  logic [MaxFieldBits-1:0]         log_waddr;
  logic [MaxFieldBits-1:0]         log_wdata;
  logic [MaxFieldBits-1:0]         log_raddr;
  logic [MaxFieldBits-1:0]         log_rdata;
  logic [MaxFieldBits-1:0]         alog_raddr;
  logic [MaxFieldBits-1:0]         alog_rdata;
  logic [MaxFieldBits:0]           sum;
  logic [MaxFieldBits-1:0]         sum_mod;

  gfle_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .poly_o  (poly),
    .fbits_o (fbits)
  );

  always_comb begin
    if (int'(fbits) < int'(gfle_pkg::MIN_FIELD_BITS)) begin
      bits_clamp = BW'(gfle_pkg::MIN_FIELD_BITS);
    end else if (int'(fbits) > int'(MaxFieldBits)) begin
      bits_clamp = BW'(MaxFieldBits);
    end else begin
      bits_clamp = BW'(fbits);
    end
  end

  assign mask   = ~({MaxFieldBits{1'b1}} << bits_q);
  assign a_in   = MaxFieldBits'(operand_a_i) & mask;
  assign b_in   = MaxFieldBits'(operand_b_i) & mask;
  assign op_in  = gfle_pkg::op_e'(opcode_i);
  assign accept = start && !busy;

  gfle_build #(
    .MaxFieldBits (MaxFieldBits)
  ) u_build (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (accept && (op_in == gfle_pkg::OP_BUILD)),
    .poly_i       (poly),
    .mask_i       (mask),
    .stat_o       (bld),
    .alog_waddr_o (alog_waddr),
    .alog_wdata_o (alog_wdata),
    .log_waddr_o  (log_waddr),
    .log_wdata_o  (log_wdata)
  );

  gfle_ram #(
    .Width (MaxFieldBits),
    .Depth (Depth)
  ) u_log_ram (
    .clk_i   (clk_i),
    .we_i    (bld.log_we),
    .waddr_i (log_waddr),
    .wdata_i (log_wdata),
    .raddr_i (log_raddr),
    .rdata_o (log_rdata)
  );

  gfle_ram #(
    .Width (MaxFieldBits),
    .Depth (Depth)
  ) u_alog_ram (
    .clk_i   (clk_i),
    .we_i    (bld.alog_we),
    .waddr_i (alog_waddr),
    .wdata_i (alog_wdata),
    .raddr_i (alog_raddr),
    .rdata_o (alog_rdata)
  );

  // log sum modulo size-1, both logs stay below size-1
  always_comb begin
    sum = {1'b0, la_q} + {1'b0, log_rdata};
    if (sum >= {1'b0, mask}) begin
      sum_mod = MaxFieldBits'(sum - {1'b0, mask});
    end else begin
      sum_mod = MaxFieldBits'(sum);
    end
  end

  assign log_raddr  = (state_q == S_LA) ? b_q : a_in;
  assign alog_raddr = (state_q == S_LB) ? sum_mod : ((mask - log_rdata) & mask);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      op_q     <= gfle_pkg::OP_MUL;
      b_q      <= '0;
      la_q     <= '0;
      bits_q   <= BW'(gfle_pkg::MIN_FIELD_BITS);
      built_q  <= 1'b0;
      valid_q  <= 1'b0;
      value_q  <= '0;
      status_q <= gfle_pkg::ST_OK;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            op_q    <= op_in;
            b_q     <= b_in;
            value_q <= '0;
            if (op_in == gfle_pkg::OP_BUILD) begin
              status_q <= gfle_pkg::ST_OK;
              valid_q  <= 1'b0;
              bits_q   <= bits_clamp;
              state_q  <= S_BUILD;
            end else if (!built_q) begin
              status_q <= gfle_pkg::ST_NOT_BUILT;
              valid_q  <= 1'b1;
            end else if (op_in == gfle_pkg::OP_MUL) begin
              status_q <= gfle_pkg::ST_OK;
              if (a_in == '0 || b_in == '0) begin
                valid_q <= 1'b1;
              end else begin
                valid_q <= 1'b0;
                state_q <= S_LA;
              end
            end else if (a_in == '0) begin
              status_q <= gfle_pkg::ST_ZERO;
              valid_q  <= 1'b1;
            end else begin
              status_q <= gfle_pkg::ST_OK;
              valid_q  <= 1'b0;
              state_q  <= S_LA;
            end
          end else begin
            valid_q <= 1'b0;
          end
        end
        S_BUILD: begin
          valid_q <= bld.done;
          if (bld.done) begin
            built_q <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        S_LA: begin
          valid_q <= (op_q == gfle_pkg::OP_LOG);
          case (op_q)
            gfle_pkg::OP_LOG: begin
              value_q <= gfle_pkg::VALUE_W'(log_rdata);
              state_q <= S_IDLE;
            end
            gfle_pkg::OP_INV: state_q <= S_AX;
            default: begin
              la_q    <= log_rdata;
              state_q <= S_LB;
            end
          endcase
        end
        S_LB: begin
          valid_q <= 1'b0;
          state_q <= S_AX;
        end
        S_AX: begin
          value_q <= gfle_pkg::VALUE_W'(alog_rdata);
          valid_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: begin
          valid_q <= 1'b0;
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy     = (state_q != S_IDLE);
  assign valid_o  = valid_q;
  assign value_o  = value_q;
  assign status_o = status_q;

  a_build_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op_in == gfle_pkg::OP_BUILD) |=> busy)
    else $error("build word did not start the sequencer");

  a_writes_only_in_build: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bld.alog_we || bld.log_we) |-> (state_q == S_BUILD))
    else $error("table write outside of build");

  a_not_built_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o == gfle_pkg::ST_NOT_BUILT) |-> !built_q)
    else $error("not-built status after tables were built");

  a_error_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (status_o == gfle_pkg::ST_OK || value_o == '0))
    else $error("error word carries a nonzero value");

endmodule

### src/gfle_ram.sv
// gfle_ram: generic single write, single registered read memory
`timescale 1ns / 1ps

module gfle_ram #(
  parameter int unsigned Width = 12,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/gfle_cfg.sv
// gfle_cfg: apb configuration registers for polynomial and field width
`timescale 1ns / 1ps

module gfle_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [gfle_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [gfle_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [gfle_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  output logic [gfle_pkg::POLY_W-1:0]         poly_o,
  output logic [gfle_pkg::FBITS_W-1:0]        fbits_o
);

  logic [gfle_pkg::POLY_W-1:0]  poly_q;
  logic [gfle_pkg::FBITS_W-1:0] fbits_q;
  gfle_pkg::reg_e               sel;

  assign sel    = gfle_pkg::reg_e'(paddr[2]);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q  <= gfle_pkg::POLY_RESET;
      fbits_q <= gfle_pkg::BITS_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (sel)
        gfle_pkg::REG_POLY: poly_q  <= pwdata[gfle_pkg::POLY_W-1:0];
        gfle_pkg::REG_BITS: fbits_q <= pwdata[gfle_pkg::FBITS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      gfle_pkg::REG_POLY: prdata = gfle_pkg::APB_DATA_W'(poly_q);
      gfle_pkg::REG_BITS: prdata = gfle_pkg::APB_DATA_W'(fbits_q);
      default:            prdata = '0;
    endcase
  end

  assign poly_o  = poly_q;
  assign fbits_o = fbits_q;

endmodule

### src/gfle_build.sv
// gfle_build: table build sequencer, antilog walk with log clear, then log fill
`timescale 1ns / 1ps

module gfle_build #(
  parameter int unsigned MaxFieldBits = gfle_pkg::MAX_FIELD_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [gfle_pkg::POLY_W-1:0]       poly_i,
  input  logic [MaxFieldBits-1:0]           mask_i,
  output gfle_pkg::bld_t                    stat_o,
  output logic [MaxFieldBits-1:0]           alog_waddr_o,
  output logic [MaxFieldBits-1:0]           alog_wdata_o,
  output logic [MaxFieldBits-1:0]           log_waddr_o,
  output logic [MaxFieldBits-1:0]           log_wdata_o
);

  localparam int unsigned XW = (MaxFieldBits + 1 > gfle_pkg::POLY_W) ?
                               MaxFieldBits + 1 : gfle_pkg::POLY_W;

  typedef enum logic [1:0] {
    B_IDLE,
    B_FILL,
    B_LOG
  } bstate_e;

  bstate_e                 state_q;
  logic [MaxFieldBits-1:0] i_q;
  logic [MaxFieldBits-1:0] x_q;
  logic                    done_q;
  logic [XW-1:0]           shifted;
  logic [XW-1:0]           wide_mask;
  logic [MaxFieldBits-1:0] x_d;

  always_comb begin
    shifted   = XW'({x_q, 1'b0});
    wide_mask = XW'(mask_i);
    if ((shifted & ~wide_mask) != '0) begin
      x_d = MaxFieldBits'((shifted ^ XW'(poly_i)) & wide_mask);
    end else begin
      x_d = MaxFieldBits'(shifted);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      i_q     <= '0;
      x_q     <= MaxFieldBits'(1);
      done_q  <= 1'b0;
    end else begin
      done_q <= (state_q == B_LOG) && (i_q == mask_i - MaxFieldBits'(1));
      unique case (state_q)
        B_IDLE: begin
          if (start_i) begin
            i_q     <= '0;
            x_q     <= MaxFieldBits'(1);
            state_q <= B_FILL;
          end
        end
        B_FILL: begin
          if (i_q == mask_i) begin
            i_q     <= '0;
            x_q     <= MaxFieldBits'(1);
            state_q <= B_LOG;
          end else begin
            i_q <= i_q + MaxFieldBits'(1);
            x_q <= x_d;
          end
        end
        B_LOG: begin
          if (i_q == mask_i - MaxFieldBits'(1)) begin
            state_q <= B_IDLE;
          end else begin
            i_q <= i_q + MaxFieldBits'(1);
            x_q <= x_d;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  assign stat_o.alog_we = (state_q == B_FILL);
  assign stat_o.log_we  = (state_q == B_FILL) || (state_q == B_LOG);
  assign stat_o.done    = done_q;

  assign alog_waddr_o = i_q;
  assign alog_wdata_o = x_q;
  assign log_waddr_o  = (state_q == B_LOG) ? x_q : i_q;
  assign log_wdata_o  = (state_q == B_LOG) ? i_q : '0;

endmodule
